>>> src/assert_macros.svh
// Assertion macros shared by the RTL of the filter block.
// No dependencies; compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check an expression at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// Check a consequent in the same cycle as its antecedent
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Check a consequent in the cycle after its antecedent
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

>>> src/sfir_pkg.sv
// Package for the symmetric FIR filter: coefficient format and tap table.
// No dependencies.
package sfir_pkg;

   localparam int COEF_W     = 16;
   localparam int COEF_FRAC  = 15;
   localparam int COEF_COUNT = 46;

   // Q1.15 low-pass taps; taps past the table are zero
   function automatic logic signed [COEF_W-1:0] coef_at(input int unsigned idx);
      logic signed [COEF_W-1:0] c;
      case (idx)
         0:  c = -16'sd772;
         1:  c = 16'sd120;
         2:  c = 16'sd137;
         3:  c = 16'sd168;
         4:  c = 16'sd212;
         5:  c = 16'sd269;
         6:  c = 16'sd335;
         7:  c = 16'sd410;
         8:  c = 16'sd493;
         9:  c = 16'sd583;
         10: c = 16'sd676;
         11: c = 16'sd772;
         12: c = 16'sd869;
         13: c = 16'sd965;
         14: c = 16'sd1058;
         15: c = 16'sd1147;
         16: c = 16'sd1229;
         17: c = 16'sd1302;
         18: c = 16'sd1368;
         19: c = 16'sd1420;
         20: c = 16'sd1461;
         21: c = 16'sd1488;
         22: c = 16'sd1502;
         23: c = 16'sd1502;
         24: c = 16'sd1488;
         25: c = 16'sd1461;
         26: c = 16'sd1420;
         27: c = 16'sd1368;
         28: c = 16'sd1302;
         29: c = 16'sd1229;
         30: c = 16'sd1147;
         31: c = 16'sd1058;
         32: c = 16'sd965;
         33: c = 16'sd869;
         34: c = 16'sd772;
         35: c = 16'sd676;
         36: c = 16'sd583;
         37: c = 16'sd493;
         38: c = 16'sd410;
         39: c = 16'sd335;
         40: c = 16'sd269;
         41: c = 16'sd212;
         42: c = 16'sd168;
         43: c = 16'sd137;
         44: c = 16'sd120;
         45: c = -16'sd772;
         default: c = '0;
      endcase
      return c;
   endfunction

endpackage

>>> src/symmetric_fir_filter_46tap.sv
// Symmetric low-pass FIR filter, top level: delay-line memory, shared MAC, sequencer.
// Depends on sfir_pkg and assert_macros.svh.
//
// Direct-form FIR filter with a built-in table of 46 symmetric Q1.15 taps. Each request
// carries one signed sample; it is written into a circular delay-line memory of TAPS
// entries, and a single multiply-accumulate unit then walks every tap, one per clock,
// reading the stored sample from the memory port and its coefficient from the table.
// The sum is rounded half up to Q1.15 and saturated to the sample range, giving one
// response per request. req_ready stays low from acceptance until the response is loaded,
// so a new request is not taken before the last is through: the walk takes one memory
// read per tap, and the read, multiply and accumulate stages then drain. The response
// sits in an output register, so a new request is taken while it waits; a response still
// waiting when the next sum is ready holds the block until it is taken.
// The delay line reads as all zeros after reset; no clearing pass is needed.
`include "assert_macros.svh"

module symmetric_fir_filter_46tap #(
   parameter int TAPS        = 46,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_in,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_out
);

   localparam int ADDR_W = $clog2(TAPS);
   localparam int PROD_W = SAMPLE_BITS + sfir_pkg::COEF_W;
   localparam int ACC_W  = PROD_W + ADDR_W + 1;
   localparam logic [ADDR_W-1:0] LAST_TAP = ADDR_W'(TAPS - 1);
   localparam logic signed [ACC_W-1:0] ROUND_INIT =
      {{(ACC_W - sfir_pkg::COEF_FRAC){1'b0}}, 1'b1, {(sfir_pkg::COEF_FRAC - 1){1'b0}}};
   localparam logic signed [ACC_W-1:0] SAT_HI =
      {{(ACC_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
   localparam logic signed [ACC_W-1:0] SAT_LO =
      {{(ACC_W - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_RUN   = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   state_type                   state_ff, state_in;
   logic [ADDR_W-1:0]           head_ff, head_in;
   logic [ADDR_W-1:0]           rd_addr_ff, rd_addr_in;
   logic [ADDR_W-1:0]           tap_cnt_ff, tap_cnt_in;
   logic [TAPS-1:0]             slot_vld_ff, slot_vld_in;
   logic                        s1_vld_ff, s2_vld_ff;
   logic                        rd_hit_ff;
   logic signed [SAMPLE_BITS-1:0] rd_data_ff;
   logic signed [sfir_pkg::COEF_W-1:0] s1_coef_ff;
   logic signed [PROD_W-1:0]    prod_ff, prod_in;
   logic signed [ACC_W-1:0]     acc_ff, acc_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic signed [SAMPLE_BITS-1:0] mem [TAPS];

   logic                        accept, issue, out_load;
   logic signed [SAMPLE_BITS-1:0] s1_sample;
   logic signed [PROD_W-1:0]    mul_a, mul_b;
   logic signed [ACC_W-1:0]     q_full;

   assign accept    = req_valid && req_ready;
   assign issue     = (state_ff == ST_RUN);
   assign req_ready = (state_ff == ST_IDLE);
   assign out_load  = (state_ff == ST_DRAIN) && !s1_vld_ff && !s2_vld_ff &&
                      (!rsp_valid_ff || rsp_ready);

   // Sequencer: write the request, walk all taps, drain the MAC pipeline
   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      rd_addr_in  = rd_addr_ff;
      tap_cnt_in  = tap_cnt_ff;
      slot_vld_in = slot_vld_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               head_in              = (head_ff == LAST_TAP) ? '0 : head_ff + 1'b1;
               slot_vld_in[head_in] = 1'b1;
               rd_addr_in           = head_in;
               tap_cnt_in           = '0;
               state_in             = ST_RUN;
            end
         end
         ST_RUN: begin
            rd_addr_in = (rd_addr_ff == '0) ? LAST_TAP : rd_addr_ff - 1'b1;
            tap_cnt_in = tap_cnt_ff + 1'b1;
            if (tap_cnt_ff == LAST_TAP) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         head_ff     <= '0;
         slot_vld_ff <= '0;
         s1_vld_ff   <= 1'b0;
         s2_vld_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         head_ff     <= head_in;
         slot_vld_ff <= slot_vld_in;
         s1_vld_ff   <= issue;
         s2_vld_ff   <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff <= rd_addr_in;
      tap_cnt_ff <= tap_cnt_in;
   end

   // Delay-line memory: write the new request, registered read per tap
   always_ff @(posedge clock) begin
      if (accept) begin
         mem[head_in] <= req_sample_in;
      end
      rd_data_ff <= mem[rd_addr_ff];
      rd_hit_ff  <= slot_vld_ff[rd_addr_ff];
      s1_coef_ff <= sfir_pkg::coef_at(int'(tap_cnt_ff));
   end

   // Multiply stage; a slot never written reads as zero
   always_comb begin
      s1_sample = rd_hit_ff ? rd_data_ff : '0;
      mul_a     = PROD_W'(s1_sample);
      mul_b     = PROD_W'(s1_coef_ff);
      prod_in   = mul_a * mul_b;
   end

   // Accumulate stage; start from the rounding bias
   always_comb begin
      acc_in = acc_ff;
      if (accept) begin
         acc_in = ROUND_INIT;
      end else if (s2_vld_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   // Scale, saturate and hold the response until taken
   always_comb begin
      q_full = acc_ff >>> sfir_pkg::COEF_FRAC;
      if (q_full > SAT_HI) begin
         rsp_data_in = SAT_HI[SAMPLE_BITS-1:0];
      end else if (q_full < SAT_LO) begin
         rsp_data_in = SAT_LO[SAMPLE_BITS-1:0];
      end else begin
         rsp_data_in = q_full[SAMPLE_BITS-1:0];
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;

   // Checks on the sequencer and MAC pipeline
   `ASSERT_NEXT(a_accept_starts_run, clock, reset, accept, (state_ff == ST_RUN) && (tap_cnt_ff == '0), "accepted request did not start the tap walk")
   `ASSERT_IMPLY(a_idle_pipe_empty, clock, reset, state_ff == ST_IDLE, !s1_vld_ff && !s2_vld_ff, "MAC pipeline busy while idle")
   `ASSERT_NEXT(a_load_gives_rsp, clock, reset, out_load, rsp_valid_ff && (state_ff == ST_IDLE), "finished sum not presented as response")
   `ASSERT_IMPLY(a_new_slot_valid, clock, reset, state_ff == ST_RUN, slot_vld_ff[head_ff], "newest delay-line slot not marked written")

endmodule
